### rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared types, character codes and the digit-to-character map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itoa_pkg;

   // Operand and digit register geometry.
   localparam int OPERAND_BITS    = 64;
   localparam int BCD_DIGITS      = 20;
   localparam int DIGIT_REG_BITS  = BCD_DIGITS * 4;
   localparam int HEX_DIGITS      = OPERAND_BITS / 4;
   localparam int MAX_FIELD_WIDTH = 64;
   localparam int POINTER_DIGITS  = 16;

   // ASCII codes.
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef enum logic [2:0] {
      MODE_SDEC = 3'd0,
      MODE_UDEC = 3'd1,
      MODE_LHEX = 3'd2,
      MODE_UHEX = 3'd3,
      MODE_BIN  = 3'd4,
      MODE_PTR  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_BIN
   } radix_type;

   typedef enum logic [1:0] {
      DG_IDLE,
      DG_DABBLE,
      DG_NORM,
      DG_READY
   } dig_state_type;

   typedef enum logic [2:0] {
      EM_IDLE,
      EM_WAIT,
      EM_PFX0,
      EM_PFXX,
      EM_LPAD,
      EM_SIGN,
      EM_ZPAD,
      EM_DIGITS
   } emit_state_type;

   // Formatting controls of one transaction, handed to the emitter.
   typedef struct packed {
      logic       ptr;
      logic       neg;
      logic       zpad;
      logic       upper;
      logic [6:0] width;
   } req_info_type;

   // Status of the digit unit seen by the emitter.
   typedef struct packed {
      logic       busy;
      logic       ready;
      logic [3:0] digit;
      logic [6:0] len;
   } dig_stat_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'b0, d};
      end else begin
         c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

### rtl/itoa_digits.sv
// ----------------------------------------------------------------------------
// Digit unit
// Converts a decimal magnitude to BCD one bit per cycle, loads hex and binary digits directly,
// strips leading zeros one digit per cycle and shifts digits out most significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_digits
   import itoa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  radix_type               radix,
   input  logic [OPERAND_BITS-1:0] mag,
   input  logic                    pop,
   output dig_stat_type            stat
);

   localparam int STEP_BITS = $clog2(OPERAND_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(OPERAND_BITS - 1);

   dig_state_type             state_ff, state_in;
   radix_type                 radix_ff, radix_in;
   logic [OPERAND_BITS-1:0]   bin_ff, bin_in;
   logic [DIGIT_REG_BITS-1:0] dreg_ff, dreg_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic [6:0]                len_ff, len_in;

   logic [DIGIT_REG_BITS-1:0] dreg_adj;
   logic [DIGIT_REG_BITS-1:0] dreg_shift;
   logic                      top_zero;

   // Add three to every BCD digit of five or more before the next shift.
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (dreg_ff[i*4 +: 4] >= 4'd5) begin
            dreg_adj[i*4 +: 4] = dreg_ff[i*4 +: 4] + 4'd3;
         end else begin
            dreg_adj[i*4 +: 4] = dreg_ff[i*4 +: 4];
         end
      end
   end

   assign dreg_shift = (radix_ff == RADIX_BIN) ? {dreg_ff[DIGIT_REG_BITS-2:0], 1'b0}
                                               : {dreg_ff[DIGIT_REG_BITS-5:0], 4'b0};
   assign top_zero   = (radix_ff == RADIX_BIN) ? !dreg_ff[DIGIT_REG_BITS-1]
                                               : (dreg_ff[DIGIT_REG_BITS-1 -: 4] == 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      radix_ff <= radix_in;
      bin_ff   <= bin_in;
      dreg_ff  <= dreg_in;
      step_ff  <= step_in;
      len_ff   <= len_in;
   end

   always_comb begin
      state_in = state_ff;
      radix_in = radix_ff;
      bin_in   = bin_ff;
      dreg_in  = dreg_ff;
      step_in  = step_ff;
      len_in   = len_ff;
      unique case (state_ff)
         DG_IDLE: begin
            if (start) begin
               radix_in = radix;
               step_in  = '0;
               unique case (radix)
                  RADIX_DEC: begin
                     bin_in   = mag;
                     dreg_in  = '0;
                     len_in   = 7'(BCD_DIGITS);
                     state_in = DG_DABBLE;
                  end
                  RADIX_HEX: begin
                     dreg_in  = {mag, (DIGIT_REG_BITS - OPERAND_BITS)'(0)};
                     len_in   = 7'(HEX_DIGITS);
                     state_in = DG_NORM;
                  end
                  default: begin
                     dreg_in  = {mag, (DIGIT_REG_BITS - OPERAND_BITS)'(0)};
                     len_in   = 7'(OPERAND_BITS);
                     state_in = DG_NORM;
                  end
               endcase
            end
         end
         DG_DABBLE: begin
            dreg_in = {dreg_adj[DIGIT_REG_BITS-2:0], bin_ff[OPERAND_BITS-1]};
            bin_in  = {bin_ff[OPERAND_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = DG_NORM;
            end
         end
         DG_NORM: begin
            if (top_zero && (len_ff > 7'd1)) begin
               dreg_in = dreg_shift;
               len_in  = len_ff - 7'd1;
            end else begin
               state_in = DG_READY;
            end
         end
         DG_READY: begin
            if (pop) begin
               dreg_in = dreg_shift;
               len_in  = len_ff - 7'd1;
               if (len_ff == 7'd1) begin
                  state_in = DG_IDLE;
               end
            end
         end
         default: state_in = DG_IDLE;
      endcase
   end

   assign stat.busy  = (state_ff != DG_IDLE);
   assign stat.ready = (state_ff == DG_READY);
   assign stat.digit = (radix_ff == RADIX_BIN) ? {3'b0, dreg_ff[DIGIT_REG_BITS-1]}
                                               : dreg_ff[DIGIT_REG_BITS-1 -: 4];
   assign stat.len   = len_ff;

endmodule

### rtl/itoa_emit.sv
// ----------------------------------------------------------------------------
// Character emitter
// Sequences prefix, padding, sign and digits into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_emit
   import itoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_info_type info,
   input  dig_stat_type dig_stat,
   output logic         dig_pop,
   output logic         idle,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast
);

   emit_state_type state_ff, state_in;
   req_info_type   info_ff, info_in;
   logic [6:0]     pad_ff, pad_in;
   logic           valid_ff, valid_in;
   logic [7:0]     data_ff, data_in;
   logic           last_ff, last_in;

   logic           out_free;
   logic           emit;
   logic [7:0]     ch;
   logic           ch_last;
   logic [6:0]     total;

   assign out_free = !valid_ff || rsp_tready;
   assign total    = dig_stat.len + {6'b0, info_ff.neg};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      info_ff <= info_in;
      pad_ff  <= pad_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      info_in  = info_ff;
      pad_in   = pad_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      dig_pop  = 1'b0;
      emit     = 1'b0;
      ch       = CHAR_SPACE;
      ch_last  = 1'b0;
      unique case (state_ff)
         EM_IDLE: begin
            if (start) begin
               info_in  = info;
               state_in = EM_WAIT;
            end
         end
         EM_WAIT: begin
            if (dig_stat.ready) begin
               pad_in   = (info_ff.width > total) ? (info_ff.width - total) : 7'd0;
               state_in = info_ff.ptr ? EM_PFX0 : EM_LPAD;
            end
         end
         EM_PFX0: begin
            if (out_free) begin
               emit     = 1'b1;
               ch       = CHAR_ZERO;
               state_in = EM_PFXX;
            end
         end
         EM_PFXX: begin
            if (out_free) begin
               emit     = 1'b1;
               ch       = CHAR_X;
               state_in = EM_LPAD;
            end
         end
         EM_LPAD: begin
            if (info_ff.zpad || (pad_ff == 7'd0)) begin
               state_in = EM_SIGN;
            end else if (out_free) begin
               emit   = 1'b1;
               ch     = CHAR_SPACE;
               pad_in = pad_ff - 7'd1;
            end
         end
         EM_SIGN: begin
            if (!info_ff.neg) begin
               state_in = EM_ZPAD;
            end else if (out_free) begin
               emit     = 1'b1;
               ch       = CHAR_MINUS;
               state_in = EM_ZPAD;
            end
         end
         EM_ZPAD: begin
            if (!info_ff.zpad || (pad_ff == 7'd0)) begin
               state_in = EM_DIGITS;
            end else if (out_free) begin
               emit   = 1'b1;
               ch     = CHAR_ZERO;
               pad_in = pad_ff - 7'd1;
            end
         end
         EM_DIGITS: begin
            if (out_free && dig_stat.ready) begin
               emit    = 1'b1;
               ch      = digit_char(dig_stat.digit, info_ff.upper);
               ch_last = (dig_stat.len == 7'd1);
               dig_pop = 1'b1;
               if (dig_stat.len == 7'd1) begin
                  state_in = EM_IDLE;
               end
            end
         end
         default: state_in = EM_IDLE;
      endcase
      if (emit) begin
         valid_in = 1'b1;
         data_in  = ch;
         last_in  = ch_last;
      end
   end

   assign idle       = (state_ff == EM_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

### rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Formats one integer conversion per transaction and streams its characters.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req_*     in          one conversion: operand, width, pad and mode
//   rsp_*     out         one ASCII character per transaction, tlast on the final
//
// Steps: the request is accepted, decimal modes run a bit-serial BCD conversion, leading
// zeros are stripped one per cycle (up to 19 decimal, 15 hex, 63 binary), the emitter takes
// the digits, then it sends any prefix, padding and sign, and then the digits themselves.
// Reset clears both sequencers and the output valid only. A stall on rsp_tready freezes
// emission; the next request is taken once the final character sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_ascii_formatter
   import itoa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // value [63:0], min_width [70:64], pad_with_zero [71]
   input  logic [71:0] req_tdata,
   // mode [2:0], operand_is_64bit [3]
   input  logic [3:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // char_out [7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   logic [OPERAND_BITS-1:0] value;
   logic [6:0]              min_width;
   logic                    pad_with_zero;
   logic [2:0]              mode_code;
   logic                    operand_is_64bit;
   mode_type                mode;
   logic                    mode_ok;

   logic [OPERAND_BITS-1:0] operand;
   logic [OPERAND_BITS-1:0] mag;
   logic                    neg;
   logic [6:0]              width_sat;
   radix_type               radix;
   req_info_type            info;

   logic                    req_accept;
   logic                    start;
   logic                    emit_idle;
   logic                    dig_pop;
   dig_stat_type            dig_stat;

   // Unpack the request transaction.
   assign value            = req_tdata[63:0];
   assign min_width        = req_tdata[70:64];
   assign pad_with_zero    = req_tdata[71];
   assign mode_code        = req_tuser[2:0];
   assign operand_is_64bit = req_tuser[3];
   assign mode             = mode_type'(mode_code);
   assign mode_ok          = (mode_code <= MODE_PTR);

   // The block takes a request whenever the emitter has finished the last one;
   // unused mode codes are taken and dropped without any output.
   assign req_tready = emit_idle;
   assign req_accept = req_tvalid && req_tready;
   assign start      = req_accept && mode_ok;

   // Narrow operands are sign extended only in signed decimal mode.
   always_comb begin
      if (operand_is_64bit) begin
         operand = value;
      end else if (mode == MODE_SDEC) begin
         operand = {{(OPERAND_BITS-32){value[31]}}, value[31:0]};
      end else begin
         operand = {(OPERAND_BITS-32)'(0), value[31:0]};
      end
   end

   // The magnitude of a negative signed value is printed behind a minus sign.
   // The most negative value negates to itself, which is its correct
   // unsigned magnitude.
   assign neg = (mode == MODE_SDEC) && operand[OPERAND_BITS-1];
   assign mag = neg ? (~operand + 64'd1) : operand;

   assign width_sat = (min_width > 7'(MAX_FIELD_WIDTH)) ? 7'(MAX_FIELD_WIDTH) : min_width;

   always_comb begin
      unique case (mode) inside
         MODE_LHEX, MODE_UHEX, MODE_PTR: radix = RADIX_HEX;
         MODE_BIN:                       radix = RADIX_BIN;
         default:                        radix = RADIX_DEC;
      endcase
   end

   // Pointer mode always prints a fixed 16 digit, zero padded field.
   assign info.ptr   = (mode == MODE_PTR);
   assign info.neg   = neg;
   assign info.zpad  = pad_with_zero || (mode == MODE_PTR);
   assign info.upper = (mode == MODE_UHEX);
   assign info.width = (mode == MODE_PTR) ? 7'(POINTER_DIGITS) : width_sat;

   itoa_digits u_digits (
      .clock (clock),
      .reset (reset),
      .start (start),
      .radix (radix),
      .mag   (mag),
      .pop   (dig_pop),
      .stat  (dig_stat)
   );

   itoa_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .info       (info),
      .dig_stat   (dig_stat),
      .dig_pop    (dig_pop),
      .idle       (emit_idle),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The digit unit must never hold work while the emitter is idle.
   assert property (@(posedge clock) disable iff (reset) emit_idle |-> !dig_stat.busy)
      else $error("digit unit busy while emitter idle");

   // Digits are only shifted out once they are normalized.
   assert property (@(posedge clock) disable iff (reset) dig_pop |-> dig_stat.ready)
      else $error("digit pop without ready digits");

   // A normalized digit register always holds at least one digit.
   assert property (@(posedge clock) disable iff (reset)
                    dig_stat.ready |-> (dig_stat.len != 7'd0))
      else $error("ready digit register is empty");

   // A valid request occupies the block in the following cycle.
   assert property (@(posedge clock) disable iff (reset) start |=> !req_tready)
      else $error("request not taken up after acceptance");

endmodule
